/* hdl/swmf_pkg.sv */
// Shared constants, operation codes and control struct for the sliding window median filter.
// Used by swmf_cell, swmf_chain, sliding_window_median_filter and swmf_checker.
package swmf_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int INDEX_BITS      = 32;
    localparam int CFG_BITS        = 7;
    // limit field covers the whole window range (up to 2047 cells)
    localparam int LIMIT_BITS      = 11;

    localparam logic [CFG_BITS-1:0] WIN_LEN_RESET = 7'd5;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;

    typedef struct packed {
        logic [1:0]            op;
        logic [LIMIT_BITS-1:0] limit;   // number of occupied cells
    } t_cell_ctl;

endpackage

/* hdl/swmf_cell.sv */
// One cell of the sorted chain: holds one sample, inserts or evicts against a broadcast word.
// Depends on swmf_pkg.
module swmf_cell #(
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                          i_clk,
    input  swmf_pkg::t_cell_ctl           i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_operand,
    input  logic                          i_left_keep,
    input  logic signed [SAMPLE_BITS-1:0] i_left_value,
    input  logic signed [SAMPLE_BITS-1:0] i_right_value,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_keep
);

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          w_occupied;
    logic                          w_shift_out;

    assign w_occupied  = swmf_pkg::LIMIT_BITS'(CELL_INDEX) < i_ctl.limit;
    // keep position: the new word lands after every value not above it
    assign o_keep      = w_occupied && (r_value <= i_operand);
    // first cell at or above the oldest word is the oldest of its equals
    assign w_shift_out = w_occupied && (r_value >= i_operand);
    assign o_value     = r_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            swmf_pkg::OP_INSERT: begin
                if (o_keep) begin
                    n_value = r_value;
                end else if (i_left_keep) begin
                    n_value = i_operand;
                end else begin
                    n_value = i_left_value;
                end
            end
            swmf_pkg::OP_EVICT: begin
                n_value = w_shift_out ? i_right_value : r_value;
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* hdl/swmf_chain.sv */
// Row of swmf_cell instances forming the value-ordered window.
// Depends on swmf_pkg and swmf_cell.
module swmf_chain #(
    parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  swmf_pkg::t_cell_ctl           i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_operand,
    output logic signed [SAMPLE_BITS-1:0] o_values [MAX_WINDOW]
);

    logic w_keep [MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic                          w_left_keep;
        logic signed [SAMPLE_BITS-1:0] w_left_value;
        logic signed [SAMPLE_BITS-1:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_keep  = 1'b1;
            assign w_left_value = i_operand;
        end else begin : g_body
            assign w_left_keep  = w_keep[g-1];
            assign w_left_value = o_values[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_tail
            assign w_right_value = i_operand;
        end else begin : g_inner
            assign w_right_value = o_values[g+1];
        end

        swmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CELL_INDEX  (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_operand     (i_operand),
            .i_left_keep   (w_left_keep),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_value       (o_values[g]),
            .o_keep        (w_keep[g])
        );
    end

endmodule

/* hdl/sliding_window_median_filter.sv */
// Top level of the sliding window median filter: age ring, series control, output register.
// Depends on swmf_pkg and swmf_chain (which uses swmf_cell).
//
//  channel   | direction | valid / ready                | payload
//  s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready | tdata: sample; tuser: start; tlast: end
//  m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready | tdata: median, index; tlast: last
//  cfg       | in        | i_cfg_valid / o_cfg_ready    | window length (7 bits)
//
// A sample that only fills the window is inserted into the chain when it is accepted; a sample
// that gives a median is inserted the same way, then the chain evicts the oldest word and
// registers the median in the busy state that follows, the age ring read for the oldest word
// sitting between the two. A result held on m_axis stalls that eviction, and s_axis with it;
// a held result alone does not block fill-only samples. A cfg word is taken only between
// samples and holds s_axis off while it is offered.
// Reset is synchronous and active low; no clearing pass.
module sliding_window_median_filter #(
    parameter int MAX_WINDOW  = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + swmf_pkg::INDEX_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [IN_W-1:0]               i_s_axis_tdata,  // sample
    input  logic                          i_s_axis_tuser,  // start_of_series
    input  logic                          i_s_axis_tlast,  // end_of_series
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [OUT_W-1:0]              o_m_axis_tdata,  // median_value, result_index
    output logic                          o_m_axis_tlast,  // last_result
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swmf_pkg::CFG_BITS-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W = (CNT_W > swmf_pkg::CFG_BITS) ? CNT_W : swmf_pkg::CFG_BITS;
    localparam int IDX_W = swmf_pkg::INDEX_BITS;

    logic [swmf_pkg::CFG_BITS-1:0] r_win_len;
    logic [CNT_W-1:0]              r_fill;
    logic [PTR_W-1:0]              r_oldest;
    logic [IDX_W-1:0]              r_emit;
    logic                          r_busy;
    logic                          r_last;
    logic                          r_out_valid;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_old_rd;
    logic                          r_bypass;
    logic signed [SAMPLE_BITS-1:0] r_out_med;
    logic [IDX_W-1:0]              r_out_idx;
    logic                          r_out_last;
    logic [SAMPLE_BITS-1:0]        r_age_mem [MAX_WINDOW];

    logic [CNT_W-1:0]              w_n;
    logic [CMP_W-1:0]              w_len_ext;
    logic                          w_in_acc;
    logic                          w_evict;
    logic                          w_clr;
    logic [CNT_W-1:0]              w_fill_eff;
    logic [PTR_W-1:0]              w_oldest_eff;
    logic [IDX_W-1:0]              w_emit_eff;
    logic [CNT_W:0]                w_slot_sum;
    logic [PTR_W-1:0]              w_slot;
    logic                          w_full;
    logic [CNT_W-1:0]              w_oldest_inc;
    logic [PTR_W-1:0]              w_oldest_next;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [SAMPLE_BITS-1:0] w_old;
    logic signed [SAMPLE_BITS-1:0] w_operand;
    logic [PTR_W-1:0]              w_lo;
    logic [PTR_W-1:0]              w_hi;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS-1:0] w_values [MAX_WINDOW];
    swmf_pkg::t_cell_ctl           w_ctl;

    // window length: zero acts as one, anything above the chain length saturates
    assign w_len_ext = CMP_W'(r_win_len);
    always_comb begin
        if (r_win_len == '0) begin
            w_n = CNT_W'(1);
        end else if (w_len_ext > CMP_W'(MAX_WINDOW)) begin
            w_n = CNT_W'(MAX_WINDOW);
        end else begin
            w_n = CNT_W'(r_win_len);
        end
    end

    // an offered cfg word goes first: hold the sample off for that cycle
    assign o_s_axis_tready = !r_busy && !i_cfg_valid;
    assign o_cfg_ready     = !r_busy;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_evict         = r_busy && (!r_out_valid || i_m_axis_tready);

    assign w_x   = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_clr = i_s_axis_tuser || (r_fill >= w_n) || (CNT_W'(r_oldest) >= w_n);

    assign w_fill_eff   = w_clr ? '0 : r_fill;
    assign w_oldest_eff = w_clr ? '0 : r_oldest;
    assign w_emit_eff   = w_clr ? '0 : r_emit;

    // both terms are below n, so one subtract folds the ring slot
    assign w_slot_sum = (CNT_W + 1)'(w_oldest_eff) + (CNT_W + 1)'(w_fill_eff);
    assign w_slot     = (w_slot_sum >= (CNT_W + 1)'(w_n)) ?
                        PTR_W'(w_slot_sum - (CNT_W + 1)'(w_n)) : PTR_W'(w_slot_sum);
    assign w_full     = ((CNT_W + 1)'(w_fill_eff) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(w_n);

    assign w_oldest_inc  = CNT_W'(r_oldest) + CNT_W'(1);
    assign w_oldest_next = (w_oldest_inc >= w_n) ? '0 : PTR_W'(w_oldest_inc);

    // slot written and read in the same cycle only when the window was empty
    assign w_old     = r_bypass ? r_x : r_old_rd;
    assign w_operand = r_busy ? w_old : w_x;

    always_comb begin
        w_ctl.op    = swmf_pkg::OP_HOLD;
        w_ctl.limit = swmf_pkg::LIMIT_BITS'(w_fill_eff);
        if (w_in_acc) begin
            w_ctl.op = swmf_pkg::OP_INSERT;
        end else if (w_evict) begin
            w_ctl.op    = swmf_pkg::OP_EVICT;
            w_ctl.limit = swmf_pkg::LIMIT_BITS'(w_n);
        end
    end

    swmf_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_operand (w_operand),
        .o_values  (w_values)
    );

    // floor of the mean of the two middle words; equal taps at odd n
    assign w_lo  = PTR_W'((w_n - CNT_W'(1)) >> 1);
    assign w_hi  = PTR_W'(w_n >> 1);
    assign w_sum = (SAMPLE_BITS + 1)'(w_values[w_lo]) + (SAMPLE_BITS + 1)'(w_values[w_hi]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= swmf_pkg::WIN_LEN_RESET;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_emit      <= '0;
            r_busy      <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_evict) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_last <= i_s_axis_tlast;
                if (w_full) begin
                    r_fill   <= w_fill_eff;
                    r_oldest <= w_oldest_eff;
                    r_emit   <= w_emit_eff;
                    r_busy   <= 1'b1;
                end else if (i_s_axis_tlast) begin
                    // series ends while the window still fills: drop it
                    r_fill   <= '0;
                    r_oldest <= '0;
                    r_emit   <= '0;
                end else begin
                    r_fill   <= w_fill_eff + CNT_W'(1);
                    r_oldest <= w_oldest_eff;
                    r_emit   <= w_emit_eff;
                end
            end
            if (w_evict) begin
                r_busy <= 1'b0;
                if (r_last) begin
                    r_fill   <= '0;
                    r_oldest <= '0;
                    r_emit   <= '0;
                end else begin
                    r_fill   <= w_n - CNT_W'(1);
                    r_oldest <= w_oldest_next;
                    r_emit   <= r_emit + IDX_W'(1);
                end
            end
            if (i_cfg_valid && !r_busy) begin
                r_win_len <= i_cfg_data;
                r_fill    <= '0;
                r_oldest  <= '0;
                r_emit    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_age_mem[w_slot] <= w_x;
            r_old_rd          <= r_age_mem[w_oldest_eff];
            r_bypass          <= (w_slot == w_oldest_eff);
            r_x               <= w_x;
        end
        if (w_evict) begin
            r_out_med  <= w_sum[SAMPLE_BITS:1];
            r_out_idx  <= r_emit;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_idx, r_out_med});
    assign o_m_axis_tlast  = r_out_last;

endmodule

/* hdl/swmf_checker.sv */
// Port-level checks for sliding_window_median_filter, attached by the bind below.
// Depends on swmf_pkg; sees the top level's ports only.
module swmf_checker #(
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W      = ((SAMPLE_BITS + swmf_pkg::INDEX_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast,
    input logic             i_cfg_valid
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("result word changed while stalled");

    // the input stalls only after an accepted sample or for an offered cfg word
    a_busy_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> ($past(i_s_axis_tvalid) || i_cfg_valid))
        else $error("input stalled without an accepted sample");

    // the filter stays busy only while the output is held
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_s_axis_tready && !i_cfg_valid && $past(!o_s_axis_tready && !i_cfg_valid)) |->
            $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("eviction stalled without output back-pressure");

    // a new result appears only out of the busy cycle
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result produced outside the eviction cycle");

endmodule

bind sliding_window_median_filter swmf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swmf_checker (.*);

/* tb/sv/tb_sliding_window_median_filter.sv */
// Self-checking bench for sliding_window_median_filter: streams sample series, predicts
// each median in a local running-median model and checks every word on the output stream.
// Depends on swmf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_sliding_window_median_filter;

    localparam int                 WIN_MAX      = swmf_pkg::MAX_WINDOW_DEF;
    localparam int                 DRAIN_CYCLES = 4;
    localparam logic signed [31:0] SAMPLE_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] SAMPLE_MAX   = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] median;
        logic [31:0]        index;
        logic               last;
    } t_median_result;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [31:0]                   i_s_axis_tdata  = '0;    // sample
    logic                          i_s_axis_tuser  = 1'b0;  // start_of_series
    logic                          i_s_axis_tlast  = 1'b0;  // end_of_series
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [63:0]                   o_m_axis_tdata;          // median_value, result_index
    logic                          o_m_axis_tlast;          // last_result
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [swmf_pkg::CFG_BITS-1:0] i_cfg_data      = '0;

    // local copy of the filter state
    logic [swmf_pkg::CFG_BITS-1:0] win_len = swmf_pkg::WIN_LEN_RESET;
    logic signed [31:0]  age_ring [WIN_MAX];
    logic signed [31:0]  sorted_list [WIN_MAX];
    int unsigned         fill_cnt   = 0;
    int unsigned         oldest_idx = 0;
    logic [31:0]         result_count = '0;

    t_median_result      pending_medians [$];
    int unsigned         mismatch_count    = 0;
    int unsigned         snd_idle_pct      = 31;
    int unsigned         rcv_idle_pct      = 59;

    sliding_window_median_filter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void clear_window();
        fill_cnt     = 0;
        oldest_idx   = 0;
        result_count = '0;
    endfunction

    function automatic bit predict_median(input logic signed [31:0] x, input bit first,
                                          input bit fin, output t_median_result res);
        int unsigned        n, pos, k, j, slot, lo, hi;
        logic signed [32:0] pair_sum;
        logic signed [31:0] oldest_val;
        bit                 got;
        n   = (win_len == 0) ? 1 : ((win_len > WIN_MAX) ? WIN_MAX : win_len);
        got = 1'b0;
        res = '0;
        if (first || fill_cnt >= n || oldest_idx >= n)
            clear_window();
        // insert after every retained value <= x, so ties keep age order
        pos = 0;
        while (pos < fill_cnt && sorted_list[pos] <= x)
            pos++;
        for (k = fill_cnt; k > pos; k--)
            sorted_list[k] = sorted_list[k-1];
        sorted_list[pos] = x;
        slot = (oldest_idx + fill_cnt) % n;
        age_ring[slot] = x;
        if (fill_cnt + 1 < n) begin
            fill_cnt++;
        end else begin
            lo = (n - 1) / 2;
            hi = n / 2;
            if (lo == hi) begin
                res.median = sorted_list[lo];
            end else begin
                // 33-bit sum, drop the lsb: floor of the average
                pair_sum = {sorted_list[lo][31], sorted_list[lo]}
                         + {sorted_list[hi][31], sorted_list[hi]};
                res.median = pair_sum[32:1];
            end
            res.index = result_count;
            res.last  = fin;
            result_count++;
            got = 1'b1;
            // evict the oldest word: first equal entry in the sorted list
            oldest_val = age_ring[oldest_idx];
            j = 0;
            while (j + 1 < n && sorted_list[j] < oldest_val)
                j++;
            for (k = j; k + 1 < n; k++)
                sorted_list[k] = sorted_list[k+1];
            oldest_idx = (oldest_idx + 1) % n;
            fill_cnt   = n - 1;
        end
        if (fin)
            clear_window();
        return got;
    endfunction

    task automatic send_sample(input logic signed [31:0] s, input bit first, input bit fin);
        t_median_result res;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tuser  <= first;
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (predict_median(s, first, fin, res)) begin
            pending_medians.push_back(res);
        end
    endtask

    task automatic write_window_length(input logic [swmf_pkg::CFG_BITS-1:0] len);
        i_s_axis_tvalid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge i_clk);
        // a fill-only word may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_len = len;
        clear_window();
    endtask

    // reset length 5: sample extremes, ties, restart mid-series, end while filling
    task automatic test_default_window();
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(32'sd0,     1'b0, 1'b0);
        send_sample(-32'sd1,    1'b0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(-32'sd1,    1'b0, 1'b1);
        send_sample(32'sd5,     1'b1, 1'b0);
        send_sample(32'sd6,     1'b0, 1'b1);
        send_sample(32'sd7,     1'b0, 1'b0);
        send_sample(32'sd8,     1'b1, 1'b0);
        send_sample(32'sd8,     1'b0, 1'b0);
        send_sample(32'sd8,     1'b0, 1'b0);
        send_sample(32'sd9,     1'b0, 1'b0);
        send_sample(32'sd8,     1'b0, 1'b1);
    endtask

    // even length: floor of the pair average at the range limits
    task automatic test_even_window();
        write_window_length(7'd2);
        send_sample(SAMPLE_MAX, 1'b1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0, 1'b0);
        send_sample(-32'sd1,    1'b0, 1'b0);
        send_sample(32'sd0,     1'b0, 1'b0);
        send_sample(32'sd3,     1'b0, 1'b1);
    endtask

    task automatic test_random_series(input logic [swmf_pkg::CFG_BITS-1:0] len,
                                      input int unsigned items);
        int unsigned        sent, n, run_len, i, mode;
        logic signed [31:0] base, s;
        bit                 first, fin;
        write_window_length(len);
        n    = (len == 0) ? 1 : ((len > WIN_MAX) ? WIN_MAX : len);
        sent = 0;
        while (sent < items) begin
            run_len = ($urandom_range(0, 4) != 0) ? $urandom_range(n, 3 * n + 4)
                                                  : $urandom_range(1, n + 1);
            mode    = $urandom_range(0, 3);
            base    = $urandom;
            for (i = 0; i < run_len; i++) begin
                case (mode)
                    0: s = $urandom;
                    1: s = $urandom_range(0, 7) - 4;
                    2: begin
                        case ($urandom_range(0, 5))
                            0:       s = SAMPLE_MIN;
                            1:       s = SAMPLE_MAX;
                            2:       s = 32'sd0;
                            3:       s = -32'sd1;
                            4:       s = SAMPLE_MIN + 1;
                            default: s = SAMPLE_MAX - 1;
                        endcase
                    end
                    default: s = base + $urandom_range(0, 15) - 8;
                endcase
                // mostly well-formed series, now and then a stray start or end
                first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                fin   = (i == run_len - 1) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 49) == 0);
                send_sample(s, first, fin);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_median_result want;
        i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected word median %0d index %0d last %0b", $time,
                         $signed(o_m_axis_tdata[31:0]), o_m_axis_tdata[63:32],
                         o_m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_medians.pop_front();
                if (o_m_axis_tdata[31:0] !== want.median) begin
                    $display("%0t: median expected %0d got %0d", $time, want.median,
                             $signed(o_m_axis_tdata[31:0]));
                    mismatch_count++;
                end
                if (o_m_axis_tdata[63:32] !== want.index) begin
                    $display("%0t: index expected %0d got %0d", $time, want.index,
                             o_m_axis_tdata[63:32]);
                    mismatch_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last,
                             o_m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned wait_cycles;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 31;
        rcv_idle_pct = 59;
        test_default_window();
        test_even_window();
        test_random_series(7'd5, 250);
        test_random_series(7'd0, 100);
        test_random_series(7'd64, 200);
        test_random_series(7'd3, 150);

        snd_idle_pct = 59;
        rcv_idle_pct = 31;
        test_random_series(7'd2, 150);
        test_random_series(7'd127, 200);
        test_random_series(7'd7, 150);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_series(7'd1, 100);
        test_random_series(7'd65, 150);
        test_random_series(7'd4, 100);

        i_s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_medians.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_medians.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, pending_medians.size());
        if (mismatch_count == 0 && pending_medians.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
